// ===== sv/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared constants, types and tables for the byte-stream SHA-256 engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned ByteW       = 8;
   localparam int unsigned WordW       = 32;
   localparam int unsigned BlockBytes  = 64;
   localparam int unsigned DigestWords = 8;
   localparam int unsigned Rounds      = 64;
   localparam int unsigned PosW        = $clog2(BlockBytes);
   localparam int unsigned DigAddrW    = $clog2(DigestWords);
   localparam int unsigned RndW        = $clog2(Rounds);
   localparam int unsigned LenW        = 64;

   // last byte position that still leaves room for the length field
   localparam logic [PosW-1:0]  LastPadPos = PosW'(55);
   localparam logic [ByteW-1:0] PadMarker  = 8'h80;

   // round constants
   localparam logic [WordW-1:0] RoundK [0:Rounds-1] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // initial chaining words
   localparam logic [WordW-1:0] InitHash [0:DigestWords-1] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // sequencer states
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_WBACK = 7'b0001000,
      ST_DWAIT = 7'b0010000,
      ST_DREAD = 7'b0100000,
      ST_DLOAD = 7'b1000000
   } state_type;

   // controls from the sequencer to the compression datapath
   typedef struct packed {
      logic            byte_vld;  // shift a block byte into the schedule window
      logic            word_vld;  // shift a chaining word into the working vars
      logic            rnd_en;    // run one round
      logic            wb_en;     // rotate working vars during write-back
      logic [RndW-1:0] rnd;       // round number
   } core_ctl_type;

endpackage

// ===== sv/sha256_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sha256_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sha256_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_core
// Compression datapath: 16-word message schedule window and the eight
// working variables, one round per cycle.
// ----------------------------------------------------------------------------
module sha256_core import sha256_pkg::*; (
   input  logic             clock,
   input  core_ctl_type     ctl,
   input  logic [ByteW-1:0] byte_in,
   input  logic [WordW-1:0] word_in,
   output logic [WordW-1:0] var_out
);

   localparam int unsigned WinW = 16 * WordW;

   logic [WinW-1:0]  w_ff;
   logic [WordW-1:0] v_ff [DigestWords];

   logic [WordW-1:0] w0, w1, w9, w14, w_new;
   logic [WordW-1:0] a, b, c, d, e, f, g, h;
   logic [WordW-1:0] big0, big1, choose, major, t1, t2;

   function automatic logic [WordW-1:0] ror(input logic [WordW-1:0] x, input int unsigned n);
      ror = (x >> n) | (x << (WordW - n));
   endfunction

   // schedule window taps, word 0 is the oldest
   assign w0  = w_ff[WinW-1 -: WordW];
   assign w1  = w_ff[WinW-1-WordW -: WordW];
   assign w9  = w_ff[WinW-1-9*WordW -: WordW];
   assign w14 = w_ff[WinW-1-14*WordW -: WordW];

   assign w_new = w0 + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w9
                + (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10));

   assign a = v_ff[0];
   assign b = v_ff[1];
   assign c = v_ff[2];
   assign d = v_ff[3];
   assign e = v_ff[4];
   assign f = v_ff[5];
   assign g = v_ff[6];
   assign h = v_ff[7];

   // round function
   assign big1   = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
   assign choose = (e & f) ^ (~e & g);
   assign t1     = h + big1 + choose + RoundK[ctl.rnd] + w0;
   assign big0   = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
   assign major  = (a & b) ^ (a & c) ^ (b & c);
   assign t2     = big0 + major;

   // schedule window: bytes during load, new words during rounds
   always_ff @(posedge clock) begin
      if (ctl.byte_vld) begin
         w_ff <= {w_ff[WinW-ByteW-1:0], byte_in};
      end else if (ctl.rnd_en) begin
         w_ff <= {w_ff[WinW-WordW-1:0], w_new};
      end
   end

   // working variables
   always_ff @(posedge clock) begin
      if (ctl.word_vld) begin
         for (int j = 0; j < DigestWords - 1; j++) begin
            v_ff[j] <= v_ff[j+1];
         end
         v_ff[DigestWords-1] <= word_in;
      end else if (ctl.rnd_en) begin
         v_ff[7] <= g;
         v_ff[6] <= f;
         v_ff[5] <= e;
         v_ff[4] <= d + t1;
         v_ff[3] <= c;
         v_ff[2] <= b;
         v_ff[1] <= a;
         v_ff[0] <= t1 + t2;
      end else if (ctl.wb_en) begin
         for (int j = 0; j < DigestWords - 1; j++) begin
            v_ff[j] <= v_ff[j+1];
         end
         v_ff[DigestWords-1] <= v_ff[0];
      end
   end

   assign var_out = v_ff[0];

endmodule

// ===== sv/sha256_hash_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 of a byte stream, digest delivered as eight 32-bit words.
// ----------------------------------------------------------------------------
// Message bytes are written into a 64-byte block RAM, one request per cycle
// while the engine is idle. A byte that fills the block starts a compression:
// the load streams the block RAM and the chaining-word RAM into the schedule
// window and working variables, the rounds run one per cycle, and write-back
// adds the result back into the chaining-word RAM; no request is taken
// meanwhile. The request with tlast pads the message while the padding block
// is streamed (marker, zeros, length are generated on the fly) and costs one
// or two such compressions, then each digest word goes through DWAIT, DREAD
// and DLOAD into the output register, DWAIT holding while the result side
// stalls. Chaining words that were never written in the current message read
// as the initial hash values, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_hash_engine import sha256_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   localparam int unsigned CntW = PosW + 1;

   state_type             state_ff, state_in;
   logic [PosW-1:0]       pos_ff, pos_in;
   logic [LenW-1:0]       bitlen_ff, bitlen_in;
   logic                  fin_ff, fin_in;
   logic                  pad_ff, pad_in;
   logic                  mark_ff, mark_in;
   logic                  lenblk_ff, lenblk_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [DigAddrW-1:0]   dig_idx_ff, dig_idx_in;
   logic [DigestWords-1:0] cv_ff, cv_in;
   logic                  ld_vld_ff;
   logic [PosW-1:0]       ld_idx_ff;
   logic [DigAddrW-1:0]   crd_addr_ff;
   logic                  crd_vld_ff;
   logic                  rsp_valid_ff;
   logic [WordW-1:0]      rsp_data_ff;
   logic [DigAddrW-1:0]   rsp_idx_ff;
   logic                  rsp_last_ff;

   logic                  req_acc;
   logic [PosW-1:0]       pos_next;
   logic [ByteW-1:0]      buf_q, blk_byte, len_byte;
   logic [WordW-1:0]      chain_q, chain_word, chain_wdata, var_out;
   logic [DigAddrW-1:0]   crd_addr, cwr_addr;
   logic                  cwr_en;
   logic                  dig_load;
   core_ctl_type          core_ctl;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign pos_next   = pos_ff + PosW'(req_tuser);

   // block byte store
   sha256_ram #(
      .Width (ByteW),
      .Depth (BlockBytes)
   ) u_buf_ram (
      .clock   (clock),
      .wr_en   (req_acc & req_tuser),
      .wr_addr (pos_ff),
      .wr_data (req_tdata),
      .rd_addr (cnt_ff[PosW-1:0]),
      .rd_data (buf_q)
   );

   // chaining word store, read-modify-write during write-back
   assign crd_addr    = (state_ff == ST_DREAD) ? dig_idx_ff : cnt_ff[DigAddrW-1:0];
   assign cwr_en      = (state_ff == ST_WBACK) && (cnt_ff != '0);
   assign cwr_addr    = cnt_ff[DigAddrW-1:0] - DigAddrW'(1);
   assign chain_wdata = chain_word + var_out;

   sha256_ram #(
      .Width (WordW),
      .Depth (DigestWords)
   ) u_chain_ram (
      .clock   (clock),
      .wr_en   (cwr_en),
      .wr_addr (cwr_addr),
      .wr_data (chain_wdata),
      .rd_addr (crd_addr),
      .rd_data (chain_q)
   );

   // unwritten chaining words read as the initial hash
   assign chain_word = crd_vld_ff ? chain_q : InitHash[crd_addr_ff];

   // block byte as seen by the compression: stored data or padding
   assign len_byte = bitlen_ff[{~ld_idx_ff[2:0], 3'b000} +: ByteW];

   always_comb begin
      if (!pad_ff) begin
         blk_byte = buf_q;
      end else if (ld_idx_ff < pos_ff) begin
         blk_byte = buf_q;
      end else if (mark_ff && (ld_idx_ff == pos_ff)) begin
         blk_byte = PadMarker;
      end else if (lenblk_ff && (ld_idx_ff[PosW-1:3] == '1)) begin
         blk_byte = len_byte;
      end else begin
         blk_byte = '0;
      end
   end

   // datapath controls
   always_comb begin
      core_ctl.byte_vld = ld_vld_ff;
      core_ctl.word_vld = ld_vld_ff && (ld_idx_ff[PosW-1:DigAddrW] == '0);
      core_ctl.rnd_en   = (state_ff == ST_ROUND);
      core_ctl.wb_en    = cwr_en;
      core_ctl.rnd      = cnt_ff[RndW-1:0];
   end

   sha256_core u_core (
      .clock   (clock),
      .ctl     (core_ctl),
      .byte_in (blk_byte),
      .word_in (chain_word),
      .var_out (var_out)
   );

   assign dig_load = (state_ff == ST_DLOAD);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      bitlen_in  = bitlen_ff;
      fin_in     = fin_ff;
      pad_in     = pad_ff;
      mark_in    = mark_ff;
      lenblk_in  = lenblk_ff;
      cnt_in     = cnt_ff;
      dig_idx_in = dig_idx_ff;
      cv_in      = cv_ff;
      if (cwr_en) begin
         cv_in[cwr_addr] = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               pos_in = pos_next;
               if (req_tuser) begin
                  bitlen_in = bitlen_ff + LenW'(ByteW);
               end
               cnt_in = '0;
               if (req_tuser && (pos_ff == '1)) begin
                  // block full: compress data, padding may follow
                  state_in = ST_LOAD;
                  pad_in   = 1'b0;
                  fin_in   = req_tlast;
               end else if (req_tlast) begin
                  state_in  = ST_LOAD;
                  pad_in    = 1'b1;
                  mark_in   = 1'b1;
                  lenblk_in = (pos_next <= LastPadPos);
                  fin_in    = 1'b0;
               end
            end
         end
         ST_LOAD: begin
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(BlockBytes)) begin
               state_in = ST_ROUND;
               cnt_in   = '0;
            end
         end
         ST_ROUND: begin
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(Rounds - 1)) begin
               state_in = ST_WBACK;
               cnt_in   = '0;
            end
         end
         ST_WBACK: begin
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(DigestWords)) begin
               cnt_in = '0;
               if (!pad_ff) begin
                  if (fin_ff) begin
                     // message ended on a block boundary
                     state_in  = ST_LOAD;
                     pad_in    = 1'b1;
                     mark_in   = 1'b1;
                     lenblk_in = 1'b1;
                     fin_in    = 1'b0;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (!lenblk_ff) begin
                  // length spills into an extra block
                  state_in  = ST_LOAD;
                  mark_in   = 1'b0;
                  lenblk_in = 1'b1;
                  pos_in    = '0;
               end else begin
                  state_in   = ST_DWAIT;
                  dig_idx_in = '0;
               end
            end
         end
         ST_DWAIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_DREAD;
            end
         end
         ST_DREAD: begin
            state_in = ST_DLOAD;
         end
         ST_DLOAD: begin
            if (dig_idx_ff == DigAddrW'(DigestWords - 1)) begin
               // digest out: back to the initial state
               state_in  = ST_IDLE;
               cv_in     = '0;
               pos_in    = '0;
               bitlen_in = '0;
               pad_in    = 1'b0;
            end else begin
               state_in   = ST_DWAIT;
               dig_idx_in = dig_idx_ff + DigAddrW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         bitlen_ff    <= '0;
         fin_ff       <= 1'b0;
         pad_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         lenblk_ff    <= 1'b0;
         cnt_ff       <= '0;
         dig_idx_ff   <= '0;
         cv_ff        <= '0;
         ld_vld_ff    <= 1'b0;
         crd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         bitlen_ff  <= bitlen_in;
         fin_ff     <= fin_in;
         pad_ff     <= pad_in;
         mark_ff    <= mark_in;
         lenblk_ff  <= lenblk_in;
         cnt_ff     <= cnt_in;
         dig_idx_ff <= dig_idx_in;
         cv_ff      <= cv_in;
         ld_vld_ff  <= (state_ff == ST_LOAD) && !cnt_ff[CntW-1];
         crd_vld_ff <= cv_ff[crd_addr];
         if (dig_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // read-side tags and output payload
   always_ff @(posedge clock) begin
      ld_idx_ff   <= cnt_ff[PosW-1:0];
      crd_addr_ff <= crd_addr;
      if (dig_load) begin
         rsp_data_ff <= chain_word;
         rsp_idx_ff  <= dig_idx_ff;
         rsp_last_ff <= (dig_idx_ff == DigAddrW'(DigestWords - 1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
